>>> rtl/ffd_pkg.sv
// ----------------------------------------------------------------------------
// ffd_pkg: shared types and codes of the frame field decoder
// Register indexes, status and format codes, the configuration bundle and
// the decoded-result bundle that travels from the capture stage to scaling.
// ----------------------------------------------------------------------------
package ffd_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_BYTES  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_LENGTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_OFFSET  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_LENGTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_FORMAT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_MASK      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_SHIFT     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_FACTOR  = 3'd7;

   // result status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_MISMATCH  = 2'd1;
   localparam logic [1:0] STAT_BAD_FIELD = 2'd2;
   localparam logic [1:0] STAT_BAD_FMT   = 2'd3;

   // field formats
   localparam logic [3:0] FMT_U8       = 4'd0;
   localparam logic [3:0] FMT_I8       = 4'd1;
   localparam logic [3:0] FMT_U16LE    = 4'd2;
   localparam logic [3:0] FMT_U16BE    = 4'd3;
   localparam logic [3:0] FMT_I16LE    = 4'd4;
   localparam logic [3:0] FMT_I16BE    = 4'd5;
   localparam logic [3:0] FMT_ASCII    = 4'd6;
   localparam logic [3:0] FMT_BCD      = 4'd7;
   localparam logic [3:0] FMT_BITFIELD = 4'd8;

   // reset values
   localparam logic [3:0]         FIELD_LENGTH_RST = 4'd1;
   localparam logic signed [31:0] SCALE_ONE        = 32'sd65536;

   typedef struct packed {
      logic [31:0]        prefix_bytes;
      logic [2:0]         prefix_length;
      logic [7:0]         field_offset;
      logic [3:0]         field_length;
      logic [3:0]         field_format;
      logic [31:0]        bit_mask;
      logic [4:0]         bit_shift;
      logic signed [31:0] scale_factor;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               has_number;
      logic signed [63:0] raw_value;
      logic signed [31:0] scale_factor;
   } dec_result_type;

endpackage

>>> rtl/ffd_capture.sv
// ----------------------------------------------------------------------------
// ffd_capture: per-byte frame tracking and field decode
// Tracks byte position, prefix match, captured field bytes and a running
// BCD value. On the last byte of a frame it decodes the field and loads the
// result register toward the scaling pipeline.
// ----------------------------------------------------------------------------
module ffd_capture #(
   parameter int FRAME_LIMIT     = 256,
   parameter int MAX_FIELD_BYTES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ffd_pkg::cfg_type       cfg,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_end_of_frame,
   output logic                   dec_valid,
   output ffd_pkg::dec_result_type dec,
   input  logic                   dec_ready
);
   import ffd_pkg::*;

   localparam int POS_W = $clog2(FRAME_LIMIT + 1);
   localparam int CNT_W = $clog2(MAX_FIELD_BYTES + 1);
   localparam int CMP_W = ((POS_W > 9) ? POS_W : 9) + 1;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             match_ff, match_in;
   logic [31:0]      acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]      bcd_ff, bcd_in;
   logic             dec_valid_ff;
   dec_result_type   dec_ff, dec_in;

   logic             accept;
   logic             in_frame;
   logic [2:0]       plen;
   logic [CMP_W-1:0] pos_ext, off_ext, end_ext;
   logic             take;
   logic             mismatch;
   logic [7:0]       digit;
   logic [1:0]       need;
   logic [7:0]       b0, b1;
   logic [31:0]      bitfield;
   logic [63:0]      raw;
   logic [1:0]       status;
   logic             has_num;

   assign req_stall = dec_valid_ff && !dec_ready;
   assign accept    = req_valid && !req_stall;
   assign dec_valid = dec_valid_ff;
   assign dec       = dec_ff;

   // position, prefix compare and capture window
   assign in_frame = pos_ff < POS_W'(FRAME_LIMIT);
   assign plen     = (cfg.prefix_length > 3'd4) ? 3'd4 : cfg.prefix_length;
   assign pos_ext  = CMP_W'(pos_ff);
   assign off_ext  = CMP_W'(cfg.field_offset);
   assign end_ext  = off_ext + CMP_W'(cfg.field_length);
   assign take     = in_frame && (pos_ext >= off_ext) && (pos_ext < end_ext) &&
                     (32'(cnt_ff) < 32'(MAX_FIELD_BYTES));
   assign mismatch = in_frame && (pos_ext < CMP_W'(plen)) &&
                     (cfg.prefix_bytes[{pos_ff[1:0], 3'b000} +: 8] != req_data_byte);

   // packed BCD digit pair, nibbles used at binary weight
   assign digit = {1'b0, req_data_byte[7:4], 3'b000} +
                  {3'b000, req_data_byte[7:4], 1'b0} +
                  {4'b0000, req_data_byte[3:0]};

   // next frame state
   always_comb begin
      pos_in   = in_frame ? pos_ff + POS_W'(1) : pos_ff;
      match_in = match_ff && !mismatch;
      cnt_in   = take ? cnt_ff + CNT_W'(1) : cnt_ff;
      acc_in   = acc_ff;
      if (take && (32'(cnt_ff) < 32'd4)) begin
         acc_in[{cnt_ff[1:0], 3'b000} +: 8] = req_data_byte;
      end
      // running value times 100 plus the new digit pair
      bcd_in = take ? ({bcd_ff[57:0], 6'b0} + {bcd_ff[58:0], 5'b0} +
                       {bcd_ff[61:0], 2'b0} + {56'b0, digit})
                    : bcd_ff;
   end

   // bytes the format needs
   always_comb begin
      case (cfg.field_format) inside
         FMT_U8, FMT_I8:                           need = 2'd1;
         FMT_U16LE, FMT_U16BE, FMT_I16LE, FMT_I16BE: need = 2'd2;
         default:                                  need = 2'd0;
      endcase
   end

   // status in priority order
   always_comb begin
      if (!match_in || (CMP_W'(pos_in) < CMP_W'(plen))) begin
         status = STAT_MISMATCH;
      end else if ((end_ext > CMP_W'(pos_in)) ||
                   (32'(cfg.field_length) > 32'(MAX_FIELD_BYTES)) ||
                   (CMP_W'(cnt_in) != CMP_W'(cfg.field_length))) begin
         status = STAT_BAD_FIELD;
      end else if (cfg.field_format > FMT_BITFIELD) begin
         status = STAT_BAD_FMT;
      end else if (cfg.field_length < {2'b00, need}) begin
         status = STAT_BAD_FIELD;
      end else begin
         status = STAT_OK;
      end
   end

   // field value by format
   assign b0       = acc_in[7:0];
   assign b1       = acc_in[15:8];
   assign bitfield = (cfg.bit_mask != 32'd0) ? ((acc_in & cfg.bit_mask) >> cfg.bit_shift)
                                             : acc_in;

   always_comb begin
      case (cfg.field_format)
         FMT_U8:       raw = {56'b0, b0};
         FMT_I8:       raw = {{56{b0[7]}}, b0};
         FMT_U16LE:    raw = {48'b0, b1, b0};
         FMT_U16BE:    raw = {48'b0, b0, b1};
         FMT_I16LE:    raw = {{48{b1[7]}}, b1, b0};
         FMT_I16BE:    raw = {{48{b0[7]}}, b0, b1};
         FMT_BCD:      raw = bcd_in;
         FMT_BITFIELD: raw = {32'b0, bitfield};
         default:      raw = 64'd0;
      endcase
   end

   assign has_num = (status == STAT_OK) && (cfg.field_format != FMT_ASCII);

   always_comb begin
      dec_in.status       = status;
      dec_in.has_number   = has_num;
      dec_in.raw_value    = has_num ? raw : 64'sd0;
      dec_in.scale_factor = cfg.scale_factor;
   end

   // frame state, cleared after every last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         match_ff <= 1'b1;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         bcd_ff   <= '0;
      end else if (accept) begin
         if (req_end_of_frame) begin
            pos_ff   <= '0;
            match_ff <= 1'b1;
            acc_ff   <= '0;
            cnt_ff   <= '0;
            bcd_ff   <= '0;
         end else begin
            pos_ff   <= pos_in;
            match_ff <= match_in;
            acc_ff   <= acc_in;
            cnt_ff   <= cnt_in;
            bcd_ff   <= bcd_in;
         end
      end
   end

   // decoded result register
   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         dec_valid_ff <= accept && req_end_of_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         dec_ff <= dec_in;
      end
   end

endmodule

>>> rtl/ffd_scale.sv
// ----------------------------------------------------------------------------
// ffd_scale: Q16.16 scaling with saturation
// Four stages: sign/magnitude, two 32x32 partial products, combine with
// high-part overflow check, clamp and sign restore into the result register.
// ----------------------------------------------------------------------------
module ffd_scale (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    dec_valid,
   input  ffd_pkg::dec_result_type dec,
   output logic                    dec_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_status,
   output logic                    rsp_has_number,
   output logic signed [63:0]      rsp_raw_value,
   output logic signed [63:0]      rsp_scaled_value
);
   import ffd_pkg::*;

   // stage valids and ready chain
   logic mag_v_ff, mul_v_ff, sum_v_ff, out_v_ff;
   logic mag_rdy, mul_rdy, sum_rdy, out_rdy;

   // fields carried along every stage
   logic [1:0]  mag_stat_ff, mul_stat_ff, sum_stat_ff, out_stat_ff;
   logic        mag_has_ff, mul_has_ff, sum_has_ff, out_has_ff;
   logic [63:0] mag_raw_ff, mul_raw_ff, sum_raw_ff, out_raw_ff;
   logic        mag_neg_ff, mul_neg_ff, sum_neg_ff;

   logic [63:0] rmag_ff, rmag_in;
   logic [31:0] smag_ff, smag_in;
   logic [63:0] hp_ff, lp_ff;
   logic [63:0] mag_ff, mag_in;
   logic        sat_ff, sat_in;
   logic [63:0] limit, scaled_in, out_scaled_ff;

   assign out_rdy   = !out_v_ff || !rsp_stall;
   assign sum_rdy   = !sum_v_ff || out_rdy;
   assign mul_rdy   = !mul_v_ff || sum_rdy;
   assign mag_rdy   = !mag_v_ff || mul_rdy;
   assign dec_ready = mag_rdy;

   // magnitudes of both operands
   assign rmag_in = dec.raw_value[63] ? (~dec.raw_value + 64'd1) : dec.raw_value;
   assign smag_in = dec.scale_factor[31] ? (~dec.scale_factor + 32'd1) : dec.scale_factor;

   // combine partial products; high part beyond 31 bits saturates outright
   assign sat_in = hp_ff >= 64'h0000_0000_8000_0000;
   assign mag_in = {hp_ff[31:0], 32'b0} + lp_ff;

   // clamp to the signed range and restore the sign
   assign limit = sum_neg_ff ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
   always_comb begin
      if (sat_ff || (mag_ff > limit)) begin
         scaled_in = limit;
      end else if (sum_neg_ff) begin
         scaled_in = ~mag_ff + 64'd1;
      end else begin
         scaled_in = mag_ff;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         mag_v_ff <= 1'b0;
         mul_v_ff <= 1'b0;
         sum_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (mag_rdy) mag_v_ff <= dec_valid;
         if (mul_rdy) mul_v_ff <= mag_v_ff;
         if (sum_rdy) sum_v_ff <= mul_v_ff;
         if (out_rdy) out_v_ff <= sum_v_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (mag_rdy) begin
         mag_stat_ff <= dec.status;
         mag_has_ff  <= dec.has_number;
         mag_raw_ff  <= dec.raw_value;
         mag_neg_ff  <= dec.raw_value[63] ^ dec.scale_factor[31];
         rmag_ff     <= rmag_in;
         smag_ff     <= smag_in;
      end
      if (mul_rdy) begin
         mul_stat_ff <= mag_stat_ff;
         mul_has_ff  <= mag_has_ff;
         mul_raw_ff  <= mag_raw_ff;
         mul_neg_ff  <= mag_neg_ff;
         hp_ff       <= rmag_ff[63:32] * smag_ff;
         lp_ff       <= rmag_ff[31:0] * smag_ff;
      end
      if (sum_rdy) begin
         sum_stat_ff <= mul_stat_ff;
         sum_has_ff  <= mul_has_ff;
         sum_raw_ff  <= mul_raw_ff;
         sum_neg_ff  <= mul_neg_ff;
         sat_ff      <= sat_in;
         mag_ff      <= mag_in;
      end
      if (out_rdy) begin
         out_stat_ff   <= sum_stat_ff;
         out_has_ff    <= sum_has_ff;
         out_raw_ff    <= sum_raw_ff;
         out_scaled_ff <= scaled_in;
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_status       = out_stat_ff;
   assign rsp_has_number   = out_has_ff;
   assign rsp_raw_value    = out_raw_ff;
   assign rsp_scaled_value = out_scaled_ff;

endmodule

>>> rtl/frame_field_decoder.sv
// ----------------------------------------------------------------------------
// frame_field_decoder: prefix-matched binary field extractor
// Checks a frame prefix, captures one field, decodes it and scales it by a
// signed Q16.16 factor with 64-bit saturation. One result per frame.
//
//   channel | ports                                   | beat
//   --------+-----------------------------------------+-------------------------
//   req     | req_valid/req_stall, data_byte, eof     | one frame byte
//   rsp     | rsp_valid/rsp_stall, status, raw, scaled| one result per frame
//   csr     | csr_write_enable, csr_index, data       | one register write
//
// One byte is taken every cycle unless req_stall is high; frame tracking is a
// single register stage. rsp_valid rises after the last byte has passed the
// decode register, magnitude, 32x32 partial products, combine, clamp/output.
// Five results can be held in flight; req_stall rises only when all are full
// and rsp is stalled. Synchronous reset clears frame state and configuration.
// ----------------------------------------------------------------------------
module frame_field_decoder #(
   parameter int FRAME_LIMIT     = 256,
   parameter int MAX_FIELD_BYTES = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // frame bytes
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_end_of_frame,
   // results
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic                           rsp_has_number,
   output logic signed [63:0]             rsp_raw_value,
   output logic signed [63:0]             rsp_scaled_value,
   // configuration writes
   input  logic                           csr_write_enable,
   input  logic [ffd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ffd_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import ffd_pkg::*;

   cfg_type        cfg_ff;
   logic           dec_valid;
   logic           dec_ready;
   dec_result_type dec;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prefix_bytes  <= '0;
         cfg_ff.prefix_length <= '0;
         cfg_ff.field_offset  <= '0;
         cfg_ff.field_length  <= FIELD_LENGTH_RST;
         cfg_ff.field_format  <= FMT_U8;
         cfg_ff.bit_mask      <= '0;
         cfg_ff.bit_shift     <= '0;
         cfg_ff.scale_factor  <= SCALE_ONE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PREFIX_BYTES:  cfg_ff.prefix_bytes  <= csr_write_data;
            CSR_PREFIX_LENGTH: cfg_ff.prefix_length <= csr_write_data[2:0];
            CSR_FIELD_OFFSET:  cfg_ff.field_offset  <= csr_write_data[7:0];
            CSR_FIELD_LENGTH:  cfg_ff.field_length  <= csr_write_data[3:0];
            CSR_FIELD_FORMAT:  cfg_ff.field_format  <= csr_write_data[3:0];
            CSR_BIT_MASK:      cfg_ff.bit_mask      <= csr_write_data;
            CSR_BIT_SHIFT:     cfg_ff.bit_shift     <= csr_write_data[4:0];
            CSR_SCALE_FACTOR:  cfg_ff.scale_factor  <= csr_write_data;
            default:           ;
         endcase
      end
   end

   // frame tracking and field decode
   ffd_capture #(
      .FRAME_LIMIT     (FRAME_LIMIT),
      .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
   ) u_capture (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_end_of_frame (req_end_of_frame),
      .dec_valid        (dec_valid),
      .dec              (dec),
      .dec_ready        (dec_ready)
   );

   // scaling pipeline and result register
   ffd_scale u_scale (
      .clock            (clock),
      .reset            (reset),
      .dec_valid        (dec_valid),
      .dec              (dec),
      .dec_ready        (dec_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_has_number   (rsp_has_number),
      .rsp_raw_value    (rsp_raw_value),
      .rsp_scaled_value (rsp_scaled_value)
   );

endmodule

>>> test/ffd_result_checker.sv
// ----------------------------------------------------------------------------
// ffd_result_checker: scoreboard for the frame field decoder
// Follows every register write and every accepted frame byte, works out the
// result each frame should produce (prefix check, field capture, decode and
// Q16.16 scaling with 64-bit saturation) and compares it, field by field,
// with each result beat that leaves the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffd_result_checker #(
   parameter int FRAME_LIMIT     = 256,
   parameter int MAX_FIELD_BYTES = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_end_of_frame,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [1:0]                     rsp_status,
   input  logic                           rsp_has_number,
   input  logic [63:0]                    rsp_raw_value,
   input  logic [63:0]                    rsp_scaled_value,
   input  logic                           csr_write_enable,
   input  logic [ffd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ffd_pkg::CSR_DATA_W-1:0] csr_write_data,
   output int                             mismatch_count,
   output int                             results_outstanding
);
   import ffd_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic        has_number;
      logic [63:0] raw_value;
      logic [63:0] scaled_value;
   } frame_result_type;

   localparam logic signed [95:0] Q48_MAX = 96'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [95:0] Q48_MIN = -96'sh8000_0000_0000_0000;

   // shadow of the register file and of the frame tracking
   cfg_type          cfg;
   int               frame_pos;
   logic             prefix_ok;
   logic [63:0]      field_bytes;
   int               captured;
   frame_result_type frame_results[$];
   frame_result_type want, got;
   int               errors;

   function automatic void clear_frame();
      frame_pos   = 0;
      prefix_ok   = 1'b1;
      field_bytes = '0;
      captured    = 0;
   endfunction

   // raw times signed Q16.16, clamped to the signed 64-bit range
   function automatic logic [63:0] scale_q16(input logic signed [63:0] raw,
                                             input logic signed [31:0] scale);
      logic signed [95:0] prod;
      prod = raw * scale;
      if (prod > Q48_MAX)
         return Q48_MAX[63:0];
      if (prod < Q48_MIN)
         return Q48_MIN[63:0];
      return prod[63:0];
   endfunction

   // one frame byte; returns 1 with the frame's result on the last byte
   function automatic logic decode_byte(input logic [7:0] b, input logic eof,
                                        output frame_result_type res);
      int          plen, need, off, len;
      logic [1:0]  st;
      logic        numeric;
      logic [63:0] raw;
      logic [31:0] bits;
      logic [7:0]  b0, b1, x;
      plen = (cfg.prefix_length > 3'd4) ? 4 : int'(cfg.prefix_length);
      off  = int'(cfg.field_offset);
      len  = int'(cfg.field_length);
      res  = '0;

      // bytes past the frame limit are dropped entirely
      if (frame_pos < FRAME_LIMIT) begin
         if (frame_pos < plen) begin
            if (cfg.prefix_bytes[8*frame_pos +: 8] != b)
               prefix_ok = 1'b0;
         end
         if (frame_pos >= off && frame_pos - off < len && captured < MAX_FIELD_BYTES) begin
            field_bytes[8*captured +: 8] = b;
            captured++;
         end
         frame_pos++;
      end
      if (!eof)
         return 1'b0;

      case (cfg.field_format) inside
         FMT_U8, FMT_I8: need = 1;
         FMT_U16LE, FMT_U16BE, FMT_I16LE, FMT_I16BE: need = 2;
         default: need = 0;
      endcase

      numeric = 1'b0;
      raw     = '0;
      b0      = field_bytes[7:0];
      b1      = field_bytes[15:8];
      if (!prefix_ok || frame_pos < plen)
         st = STAT_MISMATCH;
      else if (off + len > frame_pos || len > MAX_FIELD_BYTES || captured != len)
         st = STAT_BAD_FIELD;
      else if (cfg.field_format > FMT_BITFIELD)
         st = STAT_BAD_FMT;
      else if (len < need)
         st = STAT_BAD_FIELD;
      else begin
         st      = STAT_OK;
         numeric = 1'b1;
         case (cfg.field_format)
            FMT_U8:    raw = {56'd0, b0};
            FMT_I8:    raw = {{56{b0[7]}}, b0};
            FMT_U16LE: raw = {48'd0, b1, b0};
            FMT_U16BE: raw = {48'd0, b0, b1};
            FMT_I16LE: raw = {{48{b1[7]}}, b1, b0};
            FMT_I16BE: raw = {{48{b0[7]}}, b0, b1};
            FMT_ASCII: numeric = 1'b0;
            FMT_BCD: begin
               // nibbles above 9 keep their binary weight
               for (int k = 0; k < captured; k++) begin
                  x   = field_bytes[8*k +: 8];
                  raw = raw * 64'd100 + 64'(x[7:4]) * 64'd10 + 64'(x[3:0]);
               end
            end
            default: begin
               // little-endian bitfield, at most four bytes
               bits = '0;
               for (int k = 0; k < captured && k < 4; k++)
                  bits[8*k +: 8] = field_bytes[8*k +: 8];
               if (cfg.bit_mask != '0)
                  bits = (bits & cfg.bit_mask) >> cfg.bit_shift;
               raw = {32'd0, bits};
            end
         endcase
      end

      res.status     = st;
      res.has_number = numeric;
      if (numeric) begin
         res.raw_value    = raw;
         res.scaled_value = scale_q16(raw, cfg.scale_factor);
      end
      clear_frame();
      return 1'b1;
   endfunction

   function automatic void apply_write(input logic [CSR_IDX_W-1:0] idx,
                                       input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_PREFIX_BYTES:  cfg.prefix_bytes  = data;
         CSR_PREFIX_LENGTH: cfg.prefix_length = data[2:0];
         CSR_FIELD_OFFSET:  cfg.field_offset  = data[7:0];
         CSR_FIELD_LENGTH:  cfg.field_length  = data[3:0];
         CSR_FIELD_FORMAT:  cfg.field_format  = data[3:0];
         CSR_BIT_MASK:      cfg.bit_mask      = data;
         CSR_BIT_SHIFT:     cfg.bit_shift     = data[4:0];
         CSR_SCALE_FACTOR:  cfg.scale_factor  = data;
         default: ;
      endcase
   endfunction

   function automatic void compare_field(input string what, input logic [63:0] exp_v,
                                         input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t ns: rsp %s mismatch, expected %0h actual %0h",
                  $time, what, exp_v, act_v);
      end
   endfunction

   // compare outgoing beats first, then fold in incoming bytes and writes;
   // a byte taken on a write edge still sees the old registers
   always @(posedge clock) begin
      if (reset) begin
         cfg              = '0;
         cfg.field_length = FIELD_LENGTH_RST;
         cfg.scale_factor = SCALE_ONE;
         clear_frame();
         frame_results.delete();
         errors = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_has_number, rsp_raw_value, rsp_scaled_value};
            if (frame_results.size() == 0) begin
               errors++;
               $display("%0t ns: unexpected rsp beat, expected none actual %0h", $time, got);
            end else begin
               want = frame_results.pop_front();
               compare_field("status", 64'(want.status), 64'(got.status));
               compare_field("has_number", 64'(want.has_number), 64'(got.has_number));
               compare_field("raw_value", want.raw_value, got.raw_value);
               compare_field("scaled_value", want.scaled_value, got.scaled_value);
            end
         end
         if (req_valid && !req_stall) begin
            if (decode_byte(req_data_byte, req_end_of_frame, want))
               frame_results = {frame_results, want};
         end
         if (csr_write_enable)
            apply_write(csr_index, csr_write_data);
      end
      mismatch_count      <= errors;
      results_outstanding <= frame_results.size();
   end

endmodule

>>> test/tb_frame_field_decoder.sv
// ----------------------------------------------------------------------------
// tb_frame_field_decoder: frame field decoder testbench
// Directed frames hit every format, the scale extremes and the corner cases
// (prefix failures, short and long fields, wide bitfields, odd BCD digits,
// a register change inside a frame); random phases then reprogram the block
// and stream mostly well-formed frames under random gaps and back-pressure.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_frame_field_decoder;
   import ffd_pkg::*;

   localparam int         RANDOM_BYTES  = 360;
   localparam int         DRAIN_CYCLES  = 8;
   localparam int         QUIET_LIMIT   = 2000;
   localparam int         LONG_FRAME_LO = 257;
   localparam int         LONG_FRAME_HI = 266;
   localparam logic [3:0] FMT_BAD_LO    = FMT_BITFIELD + 4'd1;
   localparam logic [3:0] FMT_BAD_HI    = 4'hF;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_data_byte    = '0;
   logic                  req_end_of_frame = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic [1:0]            rsp_status;
   logic                  rsp_has_number;
   logic signed [63:0]    rsp_raw_value;
   logic signed [63:0]    rsp_scaled_value;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_write_data   = '0;

   int          mismatches;
   int          outstanding;
   logic        idling       = 1'b1;
   int          stall_left   = 0;
   int          quiet_cycles = 0;
   logic [7:0]  frame_buf[$];
   logic [31:0] cur_prefix   = '0;
   int          cur_plen     = 0;
   int          cur_off      = 0;
   int          cur_len      = 1;
   int          random_bytes = 0;

   frame_field_decoder dut (.*);

   ffd_result_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_data_byte, .req_end_of_frame,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_has_number,
      .rsp_raw_value, .rsp_scaled_value,
      .csr_write_enable, .csr_index, .csr_write_data,
      .mismatch_count(mismatches), .results_outstanding(outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // result side back-pressure in random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (idling && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_stall  <= 1'b1;
      end else
         rsp_stall <= 1'b0;
   end

   // watchdog: too long without any beat or register write
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
         quiet_cycles <= 0;
      else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t ns: no progress for %0d cycles", $time, QUIET_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // one byte beat, with an occasional gap in front of it
   task automatic send_byte(input logic [7:0] b, input logic eof);
      if (idling && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= b;
      req_end_of_frame <= eof;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_buf.size(); i++)
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
   endtask

   // byte k of the frame is payload[8k+7:8k], zero past the eighth
   task automatic send_payload(input logic [63:0] payload, input int nbytes);
      frame_buf.delete();
      for (int k = 0; k < nbytes; k++)
         frame_buf = {frame_buf, (k < 8) ? payload[8*k +: 8] : 8'h00};
      send_frame();
   endtask

   // let every result out and the pipeline go quiet
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   task automatic program_decoder(input logic [31:0] prefix, input logic [2:0] plen,
                                  input logic [7:0] off, input logic [3:0] len,
                                  input logic [3:0] fmt, input logic [31:0] mask,
                                  input logic [4:0] shift, input logic [31:0] scale);
      drain();
      write_reg(CSR_PREFIX_BYTES, prefix);
      write_reg(CSR_PREFIX_LENGTH, 32'(plen));
      write_reg(CSR_FIELD_OFFSET, 32'(off));
      write_reg(CSR_FIELD_LENGTH, 32'(len));
      write_reg(CSR_FIELD_FORMAT, 32'(fmt));
      write_reg(CSR_BIT_MASK, mask);
      write_reg(CSR_BIT_SHIFT, 32'(shift));
      write_reg(CSR_SCALE_FACTOR, scale);
      csr_write_enable <= 1'b0;
      cur_prefix = prefix;
      cur_plen   = (plen > 3'd4) ? 4 : int'(plen);
      cur_off    = int'(off);
      cur_len    = int'(len);
   endtask

   // mostly sane settings, now and then a bad field length or format
   task automatic random_setup(input logic far_field);
      logic [31:0] mask, scale, r;
      logic [3:0]  fmt, len;
      logic [7:0]  off;
      r = $urandom;
      case ($urandom_range(0, 3))
         0:       mask = '0;
         1:       mask = '1;
         default: mask = $urandom;
      endcase
      case ($urandom_range(0, 5))
         0:       scale = 32'h7FFF_FFFF;
         1:       scale = 32'h8000_0000;
         2:       scale = '0;
         3:       scale = SCALE_ONE;
         4:       scale = {{12{r[19]}}, r[19:0]};
         default: scale = r;
      endcase
      fmt = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(FMT_BAD_LO, FMT_BAD_HI))
                                       : 4'($urandom_range(FMT_U8, FMT_BITFIELD));
      len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      off = far_field ? 8'($urandom_range(248, 255)) : 8'($urandom_range(0, 12));
      program_decoder($urandom, 3'($urandom_range(0, 7)), off, len, fmt, mask,
                      5'($urandom), scale);
   endtask

   // random content, prefix bytes copied in when the frame should match
   task automatic random_frame(input int flen, input logic keep_prefix);
      frame_buf.delete();
      for (int i = 0; i < flen; i++)
         frame_buf = {frame_buf, (keep_prefix && i < cur_plen) ? cur_prefix[8*i +: 8]
                                                               : 8'($urandom)};
   endtask

   initial begin
      int phase, needed, flen;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: u8 at offset 0, unity scale
      send_payload(64'h80, 1);

      // the 8 and 16 bit formats; some fields hold bytes past what the format uses
      program_decoder('0, 3'd0, 8'd0, 4'd2, FMT_U8, '0, 5'd0, 32'hFFFF_0000);
      send_payload(64'h00FF, 2);
      program_decoder('0, 3'd0, 8'd0, 4'd1, FMT_I8, '0, 5'd0, 32'h7FFF_FFFF);
      send_payload(64'h80, 1);
      program_decoder('0, 3'd0, 8'd0, 4'd2, FMT_U16LE, '0, 5'd0, SCALE_ONE);
      send_payload(64'hFFFF, 2);
      program_decoder('0, 3'd0, 8'd0, 4'd3, FMT_U16BE, '0, 5'd0, 32'h0000_0001);
      send_payload(64'h56_3412, 3);
      program_decoder('0, 3'd0, 8'd0, 4'd2, FMT_I16LE, '0, 5'd0, 32'h8000_0000);
      send_payload(64'h8000, 2);

      // two-byte prefix: match, wrong byte, frame ends inside the prefix
      program_decoder(32'h0000_55AA, 3'd2, 8'd2, 4'd2, FMT_I16BE, '0, 5'd0, 32'h0001_8000);
      send_payload(64'hFF7F_55AA, 4);
      send_payload(64'h54AA, 2);
      send_payload(64'hAA, 1);

      program_decoder('0, 3'd0, 8'd0, 4'd2, FMT_ASCII, '0, 5'd0, SCALE_ONE);
      send_payload(64'h4241, 2);

      // prefix length above four compares four bytes; empty BCD field
      program_decoder(32'h0403_0201, 3'd7, 8'd4, 4'd0, FMT_BCD, '0, 5'd0, SCALE_ONE);
      send_payload(64'h0403_0201, 4);

      // BCD with nibbles above 9, saturating both ways
      program_decoder('0, 3'd0, 8'd0, 4'd5, FMT_BCD, '0, 5'd0, 32'h8000_0000);
      send_payload(64'hFA_9999_9999, 5);
      program_decoder('0, 3'd0, 8'd0, 4'd8, FMT_BCD, '0, 5'd0, 32'h7FFF_FFFF);
      send_payload(64'hFF99_9999_9999_99AF, 8);

      // bitfields: five bytes with full mask and top shift, no mask, empty
      program_decoder('0, 3'd0, 8'd0, 4'd5, FMT_BITFIELD, '1, 5'd31, 32'h7FFF_FFFF);
      send_payload(64'hFF_8000_0000, 5);
      program_decoder('0, 3'd0, 8'd0, 4'd4, FMT_BITFIELD, '0, 5'd7, 32'h7FFF_FFFF);
      send_payload(64'hDEAD_BEEF, 4);
      program_decoder('0, 3'd0, 8'd0, 4'd0, FMT_BITFIELD, 32'h0000_00F0, 5'd4, SCALE_ONE);
      send_payload(64'h5A, 1);

      // field too short for 16 bits, field over eight bytes, bad format
      program_decoder('0, 3'd0, 8'd0, 4'd1, FMT_I16LE, '0, 5'd0, SCALE_ONE);
      send_payload(64'h12, 1);
      program_decoder('0, 3'd0, 8'd0, 4'd9, FMT_U8, '0, 5'd0, SCALE_ONE);
      send_payload(64'h0807_0605_0403_0201, 9);
      program_decoder('0, 3'd0, 8'd0, 4'd1, FMT_BAD_LO, '0, 5'd0, SCALE_ONE);
      send_payload(64'h00, 1);

      // field length shrinks after three bytes were captured
      program_decoder('0, 3'd0, 8'd0, 4'd3, FMT_U8, '0, 5'd0, SCALE_ONE);
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b0);
      send_byte(8'h33, 1'b0);
      drain();
      write_reg(CSR_FIELD_LENGTH, 32'd1);
      csr_write_enable <= 1'b0;
      send_byte(8'h44, 1'b1);

      // random phases; the last stretch runs with no gaps or stalls
      phase = 0;
      while (random_bytes < RANDOM_BYTES) begin
         if (random_bytes > RANDOM_BYTES * 3 / 4)
            idling <= 1'b0;
         if (phase == 2) begin
            // one frame past the length limit, field near its end
            random_setup(1'b1);
            random_frame($urandom_range(LONG_FRAME_LO, LONG_FRAME_HI), 1'b1);
            send_frame();
            random_bytes += frame_buf.size();
         end else begin
            random_setup(1'b0);
            repeat ($urandom_range(4, 10)) begin
               needed = (cur_off + cur_len > cur_plen) ? cur_off + cur_len : cur_plen;
               if (needed == 0)
                  needed = 1;
               flen = ($urandom_range(0, 7) != 0) ? needed + $urandom_range(0, 2)
                                                  : $urandom_range(1, needed + 3);
               random_frame(flen, $urandom_range(0, 7) != 0);
               send_frame();
               random_bytes += flen;
            end
         end
         phase++;
      end

      drain();
      @(negedge clock);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
